FILE: design/uhps_pkg.sv
package uhps_pkg;

  localparam logic [3:0] K_TICK = 4'd0;
  localparam logic [3:0] K_CTRL = 4'd1;
  localparam logic [3:0] K_INTR = 4'd2;
  localparam logic [3:0] K_ENABLE = 4'd3;
  localparam logic [3:0] K_RESET = 4'd4;
  localparam logic [3:0] K_RESUME = 4'd5;
  localparam logic [3:0] K_REJECT = 4'd6;
  localparam logic [3:0] K_SUSPEND = 4'd7;
  localparam logic [3:0] K_UNINST = 4'd8;

  localparam logic [3:0] W_NONE = 4'd0;
  localparam logic [3:0] W_DESC = 4'd1;
  localparam logic [3:0] W_POWER = 4'd2;
  localparam logic [3:0] W_HSTAT = 4'd3;
  localparam logic [3:0] W_OCCLR = 4'd4;
  localparam logic [3:0] W_OTHCLR = 4'd5;
  localparam logic [3:0] W_PSTAT = 4'd6;
  localparam logic [3:0] W_CONNCLR = 4'd7;
  localparam logic [3:0] W_RSTSET = 4'd8;
  localparam logic [3:0] W_RSTPOLL = 4'd9;
  localparam logic [3:0] W_RSTCLR = 4'd10;

  localparam logic [1:0] T_NONE = 2'd0;
  localparam logic [1:0] T_POLL = 2'd1;
  localparam logic [1:0] T_RETRY = 2'd2;

  localparam logic [2:0] A_CTRL = 3'd0;
  localparam logic [2:0] A_POLL = 3'd1;
  localparam logic [2:0] A_NOTICE = 3'd2;
  localparam logic [2:0] A_RDONE = 3'd3;
  localparam logic [2:0] A_RFAIL = 3'd4;

  localparam logic [2:0] CFG_ADDR = 3'd0;
  localparam logic [2:0] CFG_RETRY_LIM = 3'd1;
  localparam logic [2:0] CFG_POLL_LIM = 3'd2;
  localparam logic [2:0] CFG_RETRY_DLY = 3'd3;
  localparam logic [2:0] CFG_REPOLL_DLY = 3'd4;

  localparam logic [7:0] RT_DEV_IN = 8'hA0;
  localparam logic [7:0] RT_DEV_OUT = 8'h20;
  localparam logic [7:0] RT_PORT_IN = 8'hA3;
  localparam logic [7:0] RT_PORT_OUT = 8'h23;
  localparam logic [7:0] RQ_GET_STATUS = 8'd0;
  localparam logic [7:0] RQ_CLEAR = 8'd1;
  localparam logic [7:0] RQ_SET = 8'd3;
  localparam logic [7:0] RQ_GET_DESC = 8'd6;
  localparam logic [7:0] DT_HUB = 8'h29;
  localparam logic [15:0] F_PORT_SUSPEND = 16'd2;
  localparam logic [15:0] F_PORT_RESET = 16'd4;
  localparam logic [15:0] F_PORT_POWER = 16'd8;
  localparam logic [15:0] F_C_CONN = 16'd16;
  localparam logic [15:0] F_C_ENABLE = 16'd17;
  localparam logic [15:0] F_C_SUSPEND = 16'd18;
  localparam logic [15:0] F_C_OC = 16'd19;
  localparam logic [15:0] F_C_RESET = 16'd20;
  localparam logic [15:0] F_C_HUB_LP = 16'd0;
  localparam logic [15:0] F_C_HUB_OC = 16'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  req_type;
    logic [7:0]  request_code;
    logic [15:0] req_value;
    logic [15:0] req_index;
    logic [4:0]  req_length;
    logic [7:0]  notice_port;
    logic        connected;
    logic [1:0]  speed;
  } result_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       xfer_ok;
    logic [4:0] xfer_len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b5;
    logic [7:0] tp;
    logic       busy;
    logic       micro;
  } item_t;

  typedef struct packed {
    logic [3:0]  awaited_step;
    logic        hub_active;
    logic [2:0]  watched_ports;
    logic [7:0]  powered_ports;
    logic [7:0]  power_good_units;
    logic [7:0]  current_port;
    logic        poll_live;
    logic [3:0]  enable_retry_count;
    logic [15:0] tick_countdown;
    logic [1:0]  tick_action;
    logic [7:0]  reset_target;
    logic [7:0]  reset_poll_count;
    logic [6:0]  rejected_ports;
    logic [7:0]  saved_status_low;
    logic [1:0]  last_reset_speed;
    logic        reset_waiting;
  } hub_regs_t;

  typedef struct packed {
    logic [3:0] enable_retry_limit;
    logic [7:0] reset_poll_limit;
    logic [9:0] retry_delay_ms;
    logic [9:0] repoll_delay_ms;
  } cfg_t;

endpackage

FILE: design/uhps_step.sv
module uhps_step
  import uhps_pkg::*;
#(
  parameter int unsigned MaxWatchedPorts = 7
) (
  input  item_t      item_i,
  input  hub_regs_t  st_i,
  input  cfg_t       cfg_i,
  output hub_regs_t  st_o,
  output logic [1:0] res_cnt_o,
  output result_t    res0_o,
  output result_t    res1_o
);

  localparam logic [7:0] MaxP = 8'(MaxWatchedPorts);

  hub_regs_t s;
  logic [1:0] n;
  result_t r0, r1;
  result_t rq;
  logic [15:0] dly;
  logic [6:0] bit_m;
  logic [7:0] cnt_inc;
  logic found;

  assign st_o = s;
  assign res_cnt_o = n;
  assign res0_o = r0;
  assign res1_o = r1;

  always_comb begin
    s = st_i;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    rq = '0;
    dly = 16'd0;
    bit_m = 7'd0;
    cnt_inc = 8'd0;
    found = 1'b0;

    // Helper style: each emit fills the next free slot.
    priority if (item_i.kind == K_ENABLE) begin
      s.hub_active = 1'b1;
      s.enable_retry_count = 4'd0;
      r0 = '{action: A_CTRL, req_type: RT_DEV_IN, request_code: RQ_GET_DESC,
             req_value: {DT_HUB, 8'd0}, req_length: 5'd9, default: '0};
      n = 2'd1;
      s.awaited_step = W_DESC;
    end else if (item_i.kind == K_RESET) begin
      if (!st_i.hub_active) begin
        r0 = '{action: A_RFAIL, notice_port: item_i.tp, default: '0};
        n = 2'd1;
      end else begin
        s.reset_waiting = 1'b1;
        s.reset_target = item_i.tp;
        s.reset_poll_count = 8'd0;
        r0 = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_SET,
               req_value: F_PORT_RESET, req_index: {8'd0, item_i.tp}, default: '0};
        n = 2'd1;
        s.awaited_step = W_RSTSET;
      end
    end else if (st_i.hub_active) begin
      unique case (item_i.kind)
        K_TICK: begin
          if (!item_i.micro && st_i.tick_countdown != 16'd0) begin
            s.tick_countdown = st_i.tick_countdown - 16'd1;
            if (s.tick_countdown == 16'd0) begin
              s.tick_action = T_NONE;
              if (st_i.tick_action == T_POLL) begin
                if (item_i.busy) begin
                  s.tick_action = T_POLL;
                  s.tick_countdown = {6'd0, cfg_i.repoll_delay_ms};
                  if (cfg_i.repoll_delay_ms == 10'd0) s.tick_countdown = 16'd1;
                end else if (!st_i.poll_live) begin
                  r0 = '{action: A_POLL, default: '0};
                  n = 2'd1;
                  s.poll_live = 1'b1;
                end
              end else if (st_i.tick_action == T_RETRY) begin
                r0 = '{action: A_CTRL, req_type: RT_DEV_IN, request_code: RQ_GET_DESC,
                       req_value: {DT_HUB, 8'd0}, req_length: 5'd9, default: '0};
                n = 2'd1;
                s.awaited_step = W_DESC;
              end
            end
          end
        end
        K_CTRL: begin
          s.awaited_step = W_NONE;
          unique case (st_i.awaited_step)
            W_DESC, W_POWER: begin
              if (!item_i.xfer_ok || (st_i.awaited_step == W_DESC &&
                  (item_i.xfer_len < 5'd6 || item_i.b1 != DT_HUB || item_i.b2 == 8'd0)))
              begin
                if (st_i.enable_retry_count < cfg_i.enable_retry_limit) begin
                  s.enable_retry_count = st_i.enable_retry_count + 4'd1;
                  s.tick_action = T_RETRY;
                  s.tick_countdown = {6'd0, cfg_i.retry_delay_ms};
                  if (cfg_i.retry_delay_ms == 10'd0) s.tick_countdown = 16'd1;
                end
              end else if (st_i.awaited_step == W_DESC) begin
                s.power_good_units = item_i.b5;
                s.powered_ports = item_i.b2;
                s.watched_ports = (item_i.b2 > MaxP) ? 3'(MaxP) : item_i.b2[2:0];
                s.current_port = 8'd1;
                r0 = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_SET,
                       req_value: F_PORT_POWER, req_index: 16'd1, default: '0};
                n = 2'd1;
                s.awaited_step = W_POWER;
              end else if (st_i.current_port >= st_i.powered_ports) begin
                dly = {7'd0, st_i.power_good_units, 1'b0} + 16'd2;
                s.tick_action = T_POLL;
                s.tick_countdown = dly;
              end else begin
                s.current_port = st_i.current_port + 8'd1;
                r0 = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_SET,
                       req_value: F_PORT_POWER, req_index: {8'd0, s.current_port},
                       default: '0};
                n = 2'd1;
                s.awaited_step = W_POWER;
              end
            end
            W_HSTAT: begin
              if (item_i.xfer_ok && item_i.b2[1]) begin
                r0 = '{action: A_CTRL, req_type: RT_DEV_OUT, request_code: RQ_CLEAR,
                       req_value: F_C_HUB_OC, default: '0};
                n = 2'd1;
                s.awaited_step = W_OCCLR;
              end else if (item_i.xfer_ok && item_i.b2[0]) begin
                r0 = '{action: A_CTRL, req_type: RT_DEV_OUT, request_code: RQ_CLEAR,
                       req_value: F_C_HUB_LP, default: '0};
                n = 2'd1;
                s.awaited_step = W_OTHCLR;
              end else if (!st_i.poll_live) begin
                r0 = '{action: A_POLL, default: '0};
                n = 2'd1;
                s.poll_live = 1'b1;
              end
            end
            W_OCCLR: begin
              s.enable_retry_count = 4'd0;
              s.current_port = 8'd1;
              r0 = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_SET,
                     req_value: F_PORT_POWER, req_index: 16'd1, default: '0};
              n = 2'd1;
              s.awaited_step = W_POWER;
            end
            W_OTHCLR: begin
              if (!st_i.poll_live) begin
                r0 = '{action: A_POLL, default: '0};
                n = 2'd1;
                s.poll_live = 1'b1;
              end
            end
            W_PSTAT: begin
              if (item_i.xfer_ok) s.saved_status_low = item_i.b0;
              rq = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_CLEAR,
                     req_index: {8'd0, st_i.current_port}, default: '0};
              if (item_i.xfer_ok && item_i.b2[4:0] != 5'd0) begin
                priority if (item_i.b2[0]) rq.req_value = F_C_CONN;
                else if (item_i.b2[1]) rq.req_value = F_C_ENABLE;
                else if (item_i.b2[2]) rq.req_value = F_C_SUSPEND;
                else if (item_i.b2[3]) rq.req_value = F_C_OC;
                else rq.req_value = F_C_RESET;
                r0 = rq;
                n = 2'd1;
                s.awaited_step = item_i.b2[0] ? W_CONNCLR : W_OTHCLR;
              end else if (!st_i.poll_live) begin
                r0 = '{action: A_POLL, default: '0};
                n = 2'd1;
                s.poll_live = 1'b1;
              end
            end
            W_CONNCLR: begin
              if (st_i.current_port >= 8'd1 && st_i.current_port <= MaxP)
                bit_m = 7'd1 << (st_i.current_port[2:0] - 3'd1);
              if (!item_i.xfer_ok ||
                  (st_i.saved_status_low[0] && (st_i.rejected_ports & bit_m) != 7'd0))
              begin
                if (!st_i.poll_live) begin
                  r0 = '{action: A_POLL, default: '0};
                  n = 2'd1;
                  s.poll_live = 1'b1;
                end
              end else begin
                if (!st_i.saved_status_low[0]) s.rejected_ports = st_i.rejected_ports & ~bit_m;
                r0 = '{action: A_NOTICE, notice_port: st_i.current_port,
                       connected: st_i.saved_status_low[0], default: '0};
                n = 2'd1;
                if (!st_i.saved_status_low[0] && !st_i.poll_live) begin
                  r1 = '{action: A_POLL, default: '0};
                  n = 2'd2;
                  s.poll_live = 1'b1;
                end
              end
            end
            W_RSTSET, W_RSTPOLL: begin
              rq = '{action: A_CTRL, req_type: RT_PORT_IN, request_code: RQ_GET_STATUS,
                     req_index: {8'd0, st_i.reset_target}, req_length: 5'd4,
                     default: '0};
              cnt_inc = st_i.reset_poll_count + 8'd1;
              if (!item_i.xfer_ok) begin
                if (st_i.reset_waiting) begin
                  r0 = '{action: A_RFAIL, notice_port: st_i.reset_target, default: '0};
                  n = 2'd1;
                end
                s.reset_waiting = 1'b0;
              end else if (st_i.awaited_step == W_RSTSET) begin
                r0 = rq;
                n = 2'd1;
                s.awaited_step = W_RSTPOLL;
              end else if (item_i.b2[4]) begin
                priority if (item_i.b1[1]) s.last_reset_speed = 2'd0;
                else if (item_i.b1[2]) s.last_reset_speed = 2'd2;
                else s.last_reset_speed = 2'd1;
                r0 = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_CLEAR,
                       req_value: F_C_RESET, req_index: {8'd0, st_i.reset_target},
                       default: '0};
                n = 2'd1;
                s.awaited_step = W_RSTCLR;
              end else begin
                s.reset_poll_count = cnt_inc;
                if (cnt_inc < cfg_i.reset_poll_limit) begin
                  r0 = rq;
                  n = 2'd1;
                  s.awaited_step = W_RSTPOLL;
                end else begin
                  if (st_i.reset_waiting) begin
                    r0 = '{action: A_RFAIL, notice_port: st_i.reset_target,
                           default: '0};
                    n = 2'd1;
                  end
                  s.reset_waiting = 1'b0;
                end
              end
            end
            W_RSTCLR: begin
              if (st_i.reset_waiting) begin
                r0 = '{action: A_RDONE, notice_port: st_i.reset_target,
                       speed: st_i.last_reset_speed, default: '0};
                n = 2'd1;
              end
              s.reset_waiting = 1'b0;
            end
            default: ;
          endcase
        end
        K_INTR: begin
          s.poll_live = 1'b0;
          if (item_i.xfer_ok && item_i.xfer_len != 5'd0 && item_i.b0 != 8'd0 &&
              item_i.b0[0]) begin
            r0 = '{action: A_CTRL, req_type: RT_DEV_IN, request_code: RQ_GET_STATUS,
                   req_length: 5'd4, default: '0};
            n = 2'd1;
            s.awaited_step = W_HSTAT;
          end else begin
            if (item_i.xfer_ok && item_i.xfer_len != 5'd0) begin
              for (int p = 7; p >= 1; p--) begin
                if (item_i.b0[p] && 3'(p) <= st_i.watched_ports) begin
                  found = 1'b1;
                  s.current_port = 8'(p);
                end
              end
            end
            if (found) begin
              r0 = '{action: A_CTRL, req_type: RT_PORT_IN, request_code: RQ_GET_STATUS,
                     req_index: {8'd0, s.current_port}, req_length: 5'd4, default: '0};
              n = 2'd1;
              s.awaited_step = W_PSTAT;
            end else begin
              r0 = '{action: A_POLL, default: '0};
              n = 2'd1;
              s.poll_live = 1'b1;
            end
          end
        end
        K_RESUME: begin
          if (!st_i.poll_live) begin
            r0 = '{action: A_POLL, default: '0};
            n = 2'd1;
            s.poll_live = 1'b1;
          end
        end
        K_REJECT: begin
          if (item_i.tp >= 8'd1 && item_i.tp <= MaxP)
            s.rejected_ports = st_i.rejected_ports | (7'd1 << (item_i.tp[2:0] - 3'd1));
        end
        K_SUSPEND: begin
          r0 = '{action: A_CTRL, req_type: RT_PORT_OUT, request_code: RQ_SET,
                 req_value: F_PORT_SUSPEND, req_index: {8'd0, item_i.tp}, default: '0};
          n = 2'd1;
        end
        K_UNINST: begin
          s = '0;
          s.last_reset_speed = st_i.last_reset_speed;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: design/usb_hub_port_service_engine_core.sv
// Host-side service engine for one USB 2.0 hub. Each accepted event (tick, control or
// interrupt completion, host request) is registered and decided in the following cycle by
// single-pass logic on the hub state registers, which puts its zero, one or two results
// into a three-entry output queue; a new event can be taken in every cycle while the input
// side does not stall. It stalls while more than one result will be left in that queue
// after the current cycle, since the event taken now may add two more in the next one.
// The field "last" marks the final result of an event. Configuration goes through a plain
// write port; the user must write it only while the block is idle, which is not enforced.
module usb_hub_port_service_engine_core
  import uhps_pkg::*;
#(
  parameter int unsigned MAX_WATCHED_PORTS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  kind_i,
  input  logic        xfer_ok_i,
  input  logic [4:0]  xfer_len_i,
  input  logic [7:0]  resp_byte0_i,
  input  logic [7:0]  resp_byte1_i,
  input  logic [7:0]  resp_byte2_i,
  input  logic [7:0]  resp_byte5_i,
  input  logic [7:0]  target_port_i,
  input  logic        enum_busy_i,
  input  logic        micro_tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  req_type_o,
  output logic [7:0]  request_code_o,
  output logic [15:0] req_value_o,
  output logic [15:0] req_index_o,
  output logic [4:0]  req_length_o,
  output logic [7:0]  notice_port_o,
  output logic        connected_o,
  output logic [1:0]  speed_o,
  output logic        last_o
);

  // Configuration. The hub address is kept but carried by no request.
  logic [6:0] hub_addr_q;
  cfg_t       cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hub_addr_q <= 7'd0;
      cfg_q <= '{enable_retry_limit: 4'd3, reset_poll_limit: 8'd50,
                 retry_delay_ms: 10'd10, repoll_delay_ms: 10'd2};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ADDR:       hub_addr_q <= cfg_data_i[6:0] | (hub_addr_q & 7'd0);
        CFG_RETRY_LIM:  cfg_q.enable_retry_limit <= cfg_data_i[3:0];
        CFG_POLL_LIM:   cfg_q.reset_poll_limit <= cfg_data_i[7:0];
        CFG_RETRY_DLY:  cfg_q.retry_delay_ms <= cfg_data_i;
        CFG_REPOLL_DLY: cfg_q.repoll_delay_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic  in_v_q;
  item_t in_q;
  logic  in_fire;

  // Output queue of three results with a "last" flag each.
  result_t     fifo_q [3];
  logic        fifo_last_q [3];
  logic [1:0]  rd_q, wr_q;
  logic [1:0]  rd_nx, wr_nx1, wr_nx2;
  logic [1:0]  cnt_q;

  hub_regs_t  st_q, st_d;
  logic [1:0] nres;
  result_t    r0, r1;

  uhps_step #(.MaxWatchedPorts(MAX_WATCHED_PORTS)) u_step (
    .item_i(in_q), .st_i(st_q), .cfg_i(cfg_q),
    .st_o(st_d), .res_cnt_o(nres), .res0_o(r0), .res1_o(r1)
  );

  logic out_fire;
  logic [1:0] push_n;
  assign out_fire = out_valid_o && !out_stall_i;
  assign push_n = in_v_q ? nres : 2'd0;

  // Queue pointers wrap after the third entry.
  assign rd_nx  = (rd_q == 2'd2) ? 2'd0 : rd_q + 2'd1;
  assign wr_nx1 = (wr_q == 2'd2) ? 2'd0 : wr_q + 2'd1;
  assign wr_nx2 = (wr_nx1 == 2'd2) ? 2'd0 : wr_nx1 + 2'd1;

  // The item taken at this edge is decided in the next cycle and may then add two results,
  // so it is taken only while at most one result remains queued after this cycle.
  logic [1:0] cnt_after;
  assign cnt_after = cnt_q - {1'b0, out_fire} + push_n;
  assign in_stall_o = cnt_after > 2'd1;
  assign in_fire = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= '{kind: kind_i, xfer_ok: xfer_ok_i, xfer_len: xfer_len_i,
                b0: resp_byte0_i, b1: resp_byte1_i, b2: resp_byte2_i, b5: resp_byte5_i,
                tp: target_port_i, busy: enum_busy_i, micro: micro_tick_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{last_reset_speed: 2'd1, default: '0};
    end else if (in_v_q) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 2'd0;
      wr_q <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      if (out_fire) rd_q <= rd_nx;
      if (push_n == 2'd1) wr_q <= wr_nx1;
      else if (push_n == 2'd2) wr_q <= wr_nx2;
      cnt_q <= cnt_after;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n == 2'd1) begin
      fifo_q[wr_q] <= r0;
      fifo_last_q[wr_q] <= 1'b1;
    end else if (push_n == 2'd2) begin
      fifo_q[wr_q] <= r0;
      fifo_last_q[wr_q] <= 1'b0;
      fifo_q[wr_nx1] <= r1;
      fifo_last_q[wr_nx1] <= 1'b1;
    end
  end

  assign out_valid_o    = cnt_q != 2'd0;
  assign action_o       = fifo_q[rd_q].action;
  assign req_type_o     = fifo_q[rd_q].req_type;
  assign request_code_o = fifo_q[rd_q].request_code;
  assign req_value_o    = fifo_q[rd_q].req_value;
  assign req_index_o    = fifo_q[rd_q].req_index;
  assign req_length_o   = fifo_q[rd_q].req_length;
  assign notice_port_o  = fifo_q[rd_q].notice_port;
  assign connected_o    = fifo_q[rd_q].connected;
  assign speed_o        = fifo_q[rd_q].speed;
  assign last_o         = fifo_last_q[rd_q];

endmodule
